@@ design/msb_pkg.sv @@
// msb_pkg: shared constants for the multi-stack shared buffer
// command and status codes, default sizes; no dependencies
`timescale 1ns / 1ps

package msb_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 64;
  localparam int NUM_STACKS_DEF = 4;

  // field widths fixed by the transaction format
  localparam int CMD_W   = 2;
  localparam int SID_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

endpackage

@@ design/msb_stream_if.sv @@
// msb_in_if, msb_out_if: valid/ready channels of the multi-stack shared buffer
// depends on msb_pkg for field widths
`timescale 1ns / 1ps

interface msb_in_if
  import msb_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [SID_W-1:0]          stack_id;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output cmd, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input cmd, input stack_id, input push_value,
                  output ready);
endinterface

interface msb_out_if
  import msb_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [STAT_W-1:0]         status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink   (input valid, input read_value, input status, output ready);
endinterface

@@ design/multi_stack_shared_buffer.sv @@
// multi_stack_shared_buffer: several lifo stacks threaded through one data store
// depends on msb_pkg and the channel interfaces in msb_stream_if.sv
//
// usage
// - in_ch carries one command transaction: push, pop or peek on stack_id;
//   out_ch returns exactly one result transaction per command, in order
// - every command is accepted in S_IDLE, where the read of the data and link
//   memories is issued (registered read), and in S_EXEC uses the read data
//   and writes back links, data, top pointer and free head
// - no new command is accepted until the previous one has done its memory
//   read and its write-back
// - the result sits in an output register; the next command is accepted
//   while it waits, and only the write-back cycle holds when out_ch stalls
// - reset clears the top pointers to null, the free head to slot 0 and the
//   fill count to 0; no clearing pass, the first command can follow at once
// - link entries at or above the fill count were never written and read as
//   the next slot, which rebuilds the initial free chain without a sweep
// - push on a full buffer reports overflow, pop or peek on an empty or
//   nonexistent stack reports empty; the unused command reports ok, value 0
`timescale 1ns / 1ps

module multi_stack_shared_buffer
  import msb_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int NUM_STACKS = NUM_STACKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);

  // pointer holds a slot or null (encoded as DEPTH)
  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int XW = (SW > SID_W) ? SW : SID_W;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  // one-hot sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // latched command
  logic [CMD_W-1:0]          cmd_r, cmd_nxt;
  logic [SW-1:0]             sid_r, sid_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [PW-1:0]             slot_r, slot_nxt;
  logic                      ok_r, ok_nxt;
  logic [STAT_W-1:0]         fail_st_r, fail_st_nxt;

  // list state
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] hwm_r, hwm_nxt;
  logic [PW-1:0] top_r   [NUM_STACKS];
  logic [PW-1:0] top_nxt [NUM_STACKS];

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [STAT_W-1:0]         out_status_r, out_status_nxt;

  // memories
  logic [VALUE_W-1:0] data_mem [DEPTH];
  logic [PW-1:0]      link_mem [DEPTH];
  logic [VALUE_W-1:0] data_rd_r;
  logic [PW-1:0]      link_rd_r;

  logic               in_acc;
  logic               exec_go;
  logic [XW-1:0]      sid_x;
  logic [SW-1:0]      sid_idx;
  logic               sid_ok;
  logic [PW-1:0]      top_sel;
  logic [PW-1:0]      acc_slot;
  logic               acc_ok;
  logic [STAT_W-1:0]  acc_fail;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               data_we;
  logic               link_we;
  logic [PW-1:0]      link_wdata;
  logic [PW-1:0]      link_val;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.status     = out_status_r;

  // decode of the incoming command against the current list state
  assign sid_x   = XW'(in_ch.stack_id);
  assign sid_idx = sid_x[SW-1:0];
  assign sid_ok  = (32'(in_ch.stack_id) < 32'(NUM_STACKS));
  assign top_sel = sid_ok ? top_r[sid_idx] : NIL;

  always_comb begin
    case (in_ch.cmd) inside
      CMD_PUSH: begin
        acc_slot = free_head_r;
        acc_ok   = sid_ok && (free_head_r < NIL);
        acc_fail = ST_OVERFLOW;
      end
      CMD_POP, CMD_PEEK: begin
        acc_slot = top_sel;
        acc_ok   = sid_ok && (top_sel < NIL);
        acc_fail = ST_EMPTY;
      end
      default: begin
        // unused command: no change, ok status
        acc_slot = NIL;
        acc_ok   = 1'b0;
        acc_fail = ST_OK;
      end
    endcase
  end

  // read in the accept cycle, data back in the exec cycle
  assign rd_en   = in_acc && acc_ok;
  assign rd_addr = acc_slot[AW-1:0];

  // a never-written link entry holds the next slot of the initial chain
  assign link_val = ((cmd_r == CMD_PUSH) && (slot_r >= hwm_r)) ? slot_r + PW'(1)
                                                               : link_rd_r;

  assign wr_addr    = slot_r[AW-1:0];
  assign data_we    = exec_go && ok_r && (cmd_r == CMD_PUSH);
  assign link_we    = exec_go && ok_r && ((cmd_r == CMD_PUSH) || (cmd_r == CMD_POP));
  assign link_wdata = (cmd_r == CMD_PUSH) ? top_r[sid_r] : free_head_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_rd_r <= data_mem[rd_addr];
    end
    if (data_we) begin
      data_mem[wr_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_rd_r <= link_mem[rd_addr];
    end
    if (link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
  end

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    sid_nxt        = sid_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    ok_nxt         = ok_r;
    fail_st_nxt    = fail_st_r;
    free_head_nxt  = free_head_r;
    hwm_nxt        = hwm_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // capture the transaction and the decision taken on it
          cmd_nxt     = in_ch.cmd;
          sid_nxt     = sid_idx;
          val_nxt     = in_ch.push_value;
          slot_nxt    = acc_slot;
          ok_nxt      = acc_ok;
          fail_st_nxt = acc_fail;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = ok_r ? ST_OK : fail_st_r;
          if (ok_r) begin
            case (cmd_r)
              CMD_PUSH: begin
                // take the free head, link it in front of the stack top
                free_head_nxt = link_val;
                top_nxt[sid_r] = slot_r;
                if (slot_r == hwm_r) begin
                  hwm_nxt = hwm_r + PW'(1);
                end
              end
              CMD_POP: begin
                // unlink the top, give its slot back to the free list
                out_value_nxt  = data_rd_r;
                top_nxt[sid_r] = link_rd_r;
                free_head_nxt  = slot_r;
              end
              CMD_PEEK: begin
                out_value_nxt = data_rd_r;
              end
              default: begin
                out_value_nxt = '0;
              end
            endcase
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    sid_r        <= sid_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    ok_r         <= ok_nxt;
    fail_st_r    <= fail_st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter write-back");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r <= NIL)
    else $error("fill count beyond depth");

  a_free_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r <= hwm_r) || (free_head_r == NIL))
    else $error("free head points past the fill count");

  a_push_sets_top: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && ok_r && (cmd_r == CMD_PUSH)) |=> (top_r[$past(sid_r)] == $past(slot_r)))
    else $error("push did not move the stack top to the new slot");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("write-back did not load a result");

endmodule
